// ----- sv/sct_pkg.sv -----
`default_nettype none

package sct_pkg;

  // Limits on the length of one token and on the tokens in one line.
  localparam int unsigned MAX_TOKEN_BYTES_DEF = 1023;
  localparam int unsigned MAX_TOKENS_DEF = 64;

  // One input byte causes at most this many result words.
  localparam int unsigned MAX_RES = 5;
  localparam int unsigned CNT_W = $clog2(MAX_RES + 1);
  localparam int unsigned IDX_W = $clog2(MAX_RES);

  // Characters with a meaning of their own.
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_BAR   = 8'h7C;
  localparam logic [7:0] CH_TWO   = 8'h32;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_NUL   = 8'h00;

  // Result word kinds.
  typedef enum logic [1:0] {
    KIND_BYTE      = 2'd0,
    KIND_TOKEN_END = 2'd1,
    KIND_LINE_END  = 2'd2
  } tok_kind_e;

  // One result word without the line flags.
  typedef struct packed {
    tok_kind_e  kind;
    logic [7:0] data;
    logic       op;
  } tok_entry_t;

  // All result words of one input byte, in order.
  typedef struct packed {
    logic                        flag;
    logic [CNT_W-1:0]            cnt;
    tok_entry_t [MAX_RES-1:0]    ent;
  } tok_bundle_t;

  // Queue status seen by the front and the back.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Append one word to a bundle; words past the last slot are lost.
  function automatic tok_bundle_t bundle_push(tok_bundle_t b, tok_kind_e k,
                                              logic [7:0] d, logic op);
    tok_bundle_t r;
    r = b;
    if (r.cnt < CNT_W'(MAX_RES)) begin
      r.ent[IDX_W'(r.cnt)].kind = k;
      r.ent[IDX_W'(r.cnt)].data = d;
      r.ent[IDX_W'(r.cnt)].op   = op;
      r.cnt = r.cnt + 1'b1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- sv/sct_front.sv -----
`default_nettype none

module sct_front #(
  parameter int unsigned MAX_TOKEN_BYTES = sct_pkg::MAX_TOKEN_BYTES_DEF,
  parameter int unsigned MAX_TOKENS = sct_pkg::MAX_TOKENS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                take_i,
  input  wire logic [7:0]          ch_i,
  input  wire logic                end_of_line_i,
  output logic                     push_o,
  output sct_pkg::tok_bundle_t     bundle_o
);
  import sct_pkg::*;

  localparam int unsigned TLW = $clog2(MAX_TOKEN_BYTES + 1);
  localparam int unsigned TTW = $clog2(MAX_TOKENS + 1);
  localparam logic [TLW-1:0] TL_MAX = TLW'(MAX_TOKEN_BYTES);
  localparam logic [TTW-1:0] TT_MAX = TTW'(MAX_TOKENS);

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_SQ     = 2'd1,
    MODE_DQ     = 2'd2,
    MODE_BSL    = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    PEND_NONE   = 3'd0,
    PEND_GT     = 3'd1,
    PEND_BAR    = 3'd2,
    PEND_TWO    = 3'd3,
    PEND_TWO_GT = 3'd4,
    PEND_DQ_BSL = 3'd5
  } pend_e;

  // Tokenizer state together with the words produced so far.
  typedef struct packed {
    mode_e          qm;
    pend_e          pk;
    logic [7:0]     pb;
    logic [TLW-1:0] tl;
    logic [TTW-1:0] tt;
    logic           df;
    tok_bundle_t    bd;
  } ctx_t;

  mode_e          qm_q, qm_d;
  pend_e          pk_q, pk_d;
  logic [7:0]     pb_q, pb_d;
  logic [TLW-1:0] tl_q, tl_d;
  logic [TTW-1:0] tt_q, tt_d;
  logic           df_q, df_d;
  ctx_t           ctx;

  // A byte joins the current token unless a limit is reached.
  function automatic ctx_t add_byte(ctx_t c, logic [7:0] b);
    ctx_t r;
    r = c;
    if (r.tt >= TT_MAX || r.tl >= TL_MAX) begin
      r.df = 1'b1;
    end else begin
      r.bd = bundle_push(r.bd, KIND_BYTE, b, 1'b0);
      r.tl = r.tl + 1'b1;
    end
    return r;
  endfunction

  // A word token ends only if it holds at least one byte.
  function automatic ctx_t end_word(ctx_t c);
    ctx_t r;
    r = c;
    if (r.tl != '0) begin
      r.bd = bundle_push(r.bd, KIND_TOKEN_END, 8'h00, 1'b0);
      r.tl = '0;
      r.tt = r.tt + 1'b1;
    end
    return r;
  endfunction

  // An operator token of one to three bytes and its end word.
  function automatic ctx_t add_operator(ctx_t c, logic [7:0] a, logic [7:0] b,
                                        logic [7:0] d, logic [1:0] n);
    ctx_t r;
    r = c;
    if (r.tt >= TT_MAX) begin
      r.df = 1'b1;
    end else begin
      r.bd = bundle_push(r.bd, KIND_BYTE, a, 1'b0);
      if (n > 2'd1) r.bd = bundle_push(r.bd, KIND_BYTE, b, 1'b0);
      if (n > 2'd2) r.bd = bundle_push(r.bd, KIND_BYTE, d, 1'b0);
      r.bd = bundle_push(r.bd, KIND_TOKEN_END, 8'h00, 1'b1);
      r.tt = r.tt + 1'b1;
    end
    return r;
  endfunction

  // A byte with no lookahead held, by quote mode.
  function automatic ctx_t take_byte(ctx_t c, logic [7:0] ch);
    ctx_t r;
    r = c;
    case (r.qm)
      MODE_NORMAL: begin
        if (ch == CH_SPACE) begin
          r = end_word(r);
        end else if (ch == CH_GT) begin
          r = end_word(r);
          r.pk = PEND_GT;
        end else if (ch == CH_BAR) begin
          r = end_word(r);
          r.pk = PEND_BAR;
        end else if ((ch inside {CH_TWO, CH_AMP}) && r.tl == '0) begin
          r.pk = PEND_TWO;
          r.pb = ch;
        end else if (ch == CH_SQ) begin
          r.qm = MODE_SQ;
        end else if (ch == CH_DQ) begin
          r.qm = MODE_DQ;
        end else if (ch == CH_BSL) begin
          r.qm = MODE_BSL;
        end else begin
          r = add_byte(r, ch);
        end
      end
      MODE_SQ: begin
        if (ch == CH_SQ) r.qm = MODE_NORMAL;
        else r = add_byte(r, ch);
      end
      MODE_DQ: begin
        if (ch == CH_DQ) r.qm = MODE_NORMAL;
        else if (ch == CH_BSL) r.pk = PEND_DQ_BSL;
        else r = add_byte(r, ch);
      end
      default: begin
        r = add_byte(r, ch);
        r.qm = MODE_NORMAL;
      end
    endcase
    return r;
  endfunction

  // Resolve the held lookahead with the new byte, then take the byte.
  function automatic ctx_t take_with_pending(ctx_t c, logic [7:0] ch);
    ctx_t  r;
    pend_e p;
    r = c;
    p = r.pk;
    r.pk = PEND_NONE;
    case (p)
      PEND_GT: begin
        if (ch == CH_GT) return add_operator(r, CH_GT, CH_GT, CH_NUL, 2'd2);
        r = add_operator(r, CH_GT, CH_NUL, CH_NUL, 2'd1);
      end
      PEND_BAR: begin
        if (ch == CH_BAR) return add_operator(r, CH_BAR, CH_BAR, CH_NUL, 2'd2);
        r = add_operator(r, CH_BAR, CH_NUL, CH_NUL, 2'd1);
      end
      PEND_TWO: begin
        if (ch == CH_GT) begin
          r.pk = PEND_TWO_GT;
          return r;
        end
        r = add_byte(r, r.pb);
      end
      PEND_TWO_GT: begin
        if (ch == CH_GT) return add_operator(r, r.pb, CH_GT, CH_GT, 2'd3);
        r = add_operator(r, r.pb, CH_GT, CH_NUL, 2'd2);
      end
      PEND_DQ_BSL: begin
        if (ch inside {CH_DQ, CH_BSL, CH_DOLLAR}) return add_byte(r, ch);
        r = add_byte(r, CH_BSL);
      end
      default: begin
      end
    endcase
    return take_byte(r, ch);
  endfunction

  // Turn a held lookahead into its final token at the end of a line.
  function automatic ctx_t flush_pending(ctx_t c);
    ctx_t r;
    r = c;
    case (r.pk)
      PEND_GT:     r = add_operator(r, CH_GT, CH_NUL, CH_NUL, 2'd1);
      PEND_BAR:    r = add_operator(r, CH_BAR, CH_NUL, CH_NUL, 2'd1);
      PEND_TWO:    r = add_byte(r, r.pb);
      PEND_TWO_GT: r = add_operator(r, r.pb, CH_GT, CH_NUL, 2'd2);
      PEND_DQ_BSL: r = add_byte(r, CH_BSL);
      default: begin
      end
    endcase
    r.pk = PEND_NONE;
    return r;
  endfunction

  // Classify the incoming byte and build all of its result words.
  always_comb begin
    ctx.qm = qm_q;
    ctx.pk = pk_q;
    ctx.pb = pb_q;
    ctx.tl = tl_q;
    ctx.tt = tt_q;
    ctx.df = df_q;
    ctx.bd = '0;
    if (end_of_line_i || ch_i == CH_NUL) begin
      ctx = flush_pending(ctx);
      ctx = end_word(ctx);
      ctx.bd = bundle_push(ctx.bd, KIND_LINE_END, 8'h00, 1'b0);
      ctx.bd.flag = ctx.df;
      ctx.qm = MODE_NORMAL;
      ctx.pk = PEND_NONE;
      ctx.pb = '0;
      ctx.tl = '0;
      ctx.tt = '0;
      ctx.df = 1'b0;
    end else begin
      ctx = take_with_pending(ctx, ch_i);
      ctx.bd.flag = ctx.df;
    end
  end

  // The state advances only on an accepted byte.
  always_comb begin
    qm_d = qm_q;
    pk_d = pk_q;
    pb_d = pb_q;
    tl_d = tl_q;
    tt_d = tt_q;
    df_d = df_q;
    if (take_i) begin
      qm_d = ctx.qm;
      pk_d = ctx.pk;
      pb_d = ctx.pb;
      tl_d = ctx.tl;
      tt_d = ctx.tt;
      df_d = ctx.df;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qm_q <= MODE_NORMAL;
      pk_q <= PEND_NONE;
      pb_q <= '0;
      tl_q <= '0;
      tt_q <= '0;
      df_q <= 1'b0;
    end else begin
      qm_q <= qm_d;
      pk_q <= pk_d;
      pb_q <= pb_d;
      tl_q <= tl_d;
      tt_q <= tt_d;
      df_q <= df_d;
    end
  end

  // Bytes that produce no word leave nothing in the queue.
  assign push_o   = take_i && (ctx.bd.cnt != '0);
  assign bundle_o = ctx.bd;

endmodule

`default_nettype wire

// ----- sv/sct_queue.sv -----
`default_nettype none

module sct_queue (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire sct_pkg::tok_bundle_t push_data_i,
  input  wire logic                 pop_i,
  output sct_pkg::tok_bundle_t      head_o,
  output sct_pkg::q_stat_t          stat_o
);
  import sct_pkg::*;

  // Two bundle slots between the front and the back.
  tok_bundle_t [1:0] slot_q;
  logic              wr_ptr_q, wr_ptr_d;
  logic              rd_ptr_q, rd_ptr_d;
  logic [1:0]        count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Slot contents are payload and need no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign head_o       = slot_q[rd_ptr_q];
  assign stat_o.full  = (count_q == 2'd2);
  assign stat_o.empty = (count_q == 2'd0);

endmodule

`default_nettype wire

// ----- sv/sct_back.sv -----
`default_nettype none

module sct_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire sct_pkg::tok_bundle_t head_i,
  input  wire logic                 empty_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [1:0]                kind_o,
  output logic [7:0]                data_o,
  output logic                      is_operator_o,
  output logic                      overflow_o,
  output logic                      last_o
);
  import sct_pkg::*;

  logic [IDX_W-1:0] idx_q, idx_d;
  logic             valid_q, valid_d;
  logic             load;
  logic             at_last;
  tok_entry_t       cur;
  logic [1:0]       kind_q;
  logic [7:0]       data_q;
  logic             op_q;
  logic             flag_q;
  logic             last_q;

  // Walk the head bundle one word a cycle, while the output is not stalled, into the output register.
  assign cur     = head_i.ent[idx_q];
  assign at_last = (idx_q == IDX_W'(head_i.cnt - 1'b1));
  assign load    = !empty_i && (!valid_q || !out_stall_i);
  assign pop_o   = load && at_last;

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    if (load) begin
      idx_d   = at_last ? '0 : idx_q + 1'b1;
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  // Output word payload.
  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= cur.kind;
      data_q <= cur.data;
      op_q   <= cur.op;
      flag_q <= head_i.flag;
      last_q <= at_last;
    end
  end

  assign out_valid_o   = valid_q;
  assign kind_o        = kind_q;
  assign data_o        = data_q;
  assign is_operator_o = op_q;
  assign overflow_o    = flag_q;
  assign last_o        = last_q;

endmodule

`default_nettype wire

// ----- sv/shell_command_tokenizer.sv -----
// Path: the words of an accepted byte are written into a queue slot and then moved into
// the output register, from which they are taken.
// Throughput: one byte per cycle while each byte yields at most one word and the
// output is not stalled; the words of a byte leave one word per cycle, unless stalled, out of
// the single output register, with a two-bundle queue absorbing the bursts.
// Reset: asynchronous, active low; clears quote mode, lookahead, token counts,
// the queue and the output valid.
`default_nettype none

module shell_command_tokenizer #(
  parameter int unsigned MAX_TOKEN_BYTES = sct_pkg::MAX_TOKEN_BYTES_DEF,
  parameter int unsigned MAX_TOKENS = sct_pkg::MAX_TOKENS_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] ch_i,
  input  wire logic       end_of_line_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [1:0]      kind_o,
  output logic [7:0]      data_o,
  output logic            is_operator_o,
  output logic            overflow_o,
  output logic            last_o
);
  import sct_pkg::*;

  logic        take;
  logic        push;
  logic        pop;
  tok_bundle_t push_bundle;
  tok_bundle_t head;
  q_stat_t     q_stat;

  // A byte is taken whenever the queue has a free slot.
  assign in_stall_o = q_stat.full;
  assign take       = in_valid_i && !q_stat.full;

  sct_front #(
    .MAX_TOKEN_BYTES(MAX_TOKEN_BYTES),
    .MAX_TOKENS(MAX_TOKENS)
  ) u_front (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .take_i(take),
    .ch_i(ch_i),
    .end_of_line_i(end_of_line_i),
    .push_o(push),
    .bundle_o(push_bundle)
  );

  sct_queue u_queue (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .push_data_i(push_bundle),
    .pop_i(pop),
    .head_o(head),
    .stat_o(q_stat)
  );

  sct_back u_back (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .head_i(head),
    .empty_i(q_stat.empty),
    .pop_o(pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .kind_o(kind_o),
    .data_o(data_o),
    .is_operator_o(is_operator_o),
    .overflow_o(overflow_o),
    .last_o(last_o)
  );

  // The queue is never written while full nor read while empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !q_stat.full)
    else $error("bundle pushed into a full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> !q_stat.empty)
    else $error("bundle popped from an empty queue");

  // A line end is always the final word of its byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == KIND_LINE_END) |-> last_o)
    else $error("line end word not marked last");

  // Only token byte words carry data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o != KIND_BYTE) |-> (data_o == 8'h00))
    else $error("nonzero data on a non-byte word");

endmodule

`default_nettype wire
